FILE: hw/rtl/dtfp_pkg.sv
// ----------------------------------------------------------------------------
// dtfp_pkg: shared types and constants for the decimal text parser
// Character codes, parser and back end state types, power-of-ten table.
// ----------------------------------------------------------------------------
package dtfp_pkg;

	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_POINT = 8'd46;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;

	// Most positive and most negative magnitudes of the 32-bit result
	localparam logic [31:0] LIMIT_POS = 32'h7FFF_FFFF;
	localparam logic [31:0] LIMIT_NEG = 32'h8000_0000;

	typedef enum logic [1:0] {
		PH_WS,
		PH_INT,
		PH_FRAC,
		PH_END
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_FIN
	} back_state_t;

	function automatic logic [63:0] pow10(input logic [4:0] n);
		logic [63:0] r;
		unique case (n)
			5'd0:    r = 64'd1;
			5'd1:    r = 64'd10;
			5'd2:    r = 64'd100;
			5'd3:    r = 64'd1000;
			5'd4:    r = 64'd10000;
			5'd5:    r = 64'd100000;
			5'd6:    r = 64'd1000000;
			5'd7:    r = 64'd10000000;
			5'd8:    r = 64'd100000000;
			5'd9:    r = 64'd1000000000;
			5'd10:   r = 64'd10000000000;
			5'd11:   r = 64'd100000000000;
			5'd12:   r = 64'd1000000000000;
			5'd13:   r = 64'd10000000000000;
			5'd14:   r = 64'd100000000000000;
			5'd15:   r = 64'd1000000000000000;
			5'd16:   r = 64'd10000000000000000;
			5'd17:   r = 64'd100000000000000000;
			5'd18:   r = 64'd1000000000000000000;
			default: r = 64'd1;
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/dtfp_front.sv
// ----------------------------------------------------------------------------
// dtfp_front: character classifier and digit accumulator
// Walks whitespace, sign, integer and fraction digits; hands off a record at NUL.
// ----------------------------------------------------------------------------
module dtfp_front #(
	parameter int MAX_FRAC_DIGITS = 9,
	parameter int FRAC_W          = 30,
	parameter int CNT_W           = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        ch,
	output logic              rec_push,
	output logic              rec_neg,
	output logic [31:0]       rec_int,
	output logic              rec_ovf,
	output logic [FRAC_W-1:0] rec_frac,
	output logic [CNT_W-1:0]  rec_cnt
);

	dtfp_pkg::phase_t phase_q, phase_d;
	logic              neg_q;
	logic [31:0]       int_q;
	logic              ovf_q;
	logic [FRAC_W-1:0] frac_q;
	logic [CNT_W-1:0]  cnt_q;

	logic        is_nul, is_digit, is_ws;
	logic [3:0]  digit;
	logic [35:0] int_next;
	logic [FRAC_W+3:0] frac_next;
	logic        int_en, frac_en, neg_set;

	assign is_nul   = (ch == dtfp_pkg::CH_NUL);
	assign is_digit = (ch >= dtfp_pkg::CH_ZERO) && (ch <= dtfp_pkg::CH_NINE);
	assign is_ws    = (ch == dtfp_pkg::CH_SPACE) ||
	                  ((ch >= dtfp_pkg::CH_TAB) && (ch <= dtfp_pkg::CH_CR));
	assign digit    = 4'(ch - dtfp_pkg::CH_ZERO);

	// x*10 + d as two shifted copies
	assign int_next  = {1'b0, int_q, 3'b0} + {3'b0, int_q, 1'b0} + 36'(digit);
	assign frac_next = {1'b0, frac_q, 3'b0} + {3'b0, frac_q, 1'b0} + (FRAC_W+4)'(digit);

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			dtfp_pkg::PH_WS: begin
				priority if (is_ws)                      phase_d = dtfp_pkg::PH_WS;
				else if (ch == dtfp_pkg::CH_MINUS ||
				         ch == dtfp_pkg::CH_PLUS || is_digit) phase_d = dtfp_pkg::PH_INT;
				else if (ch == dtfp_pkg::CH_POINT)       phase_d = dtfp_pkg::PH_FRAC;
				else                                     phase_d = dtfp_pkg::PH_END;
			end
			dtfp_pkg::PH_INT: begin
				priority if (is_digit)                   phase_d = dtfp_pkg::PH_INT;
				else if (ch == dtfp_pkg::CH_POINT)       phase_d = dtfp_pkg::PH_FRAC;
				else                                     phase_d = dtfp_pkg::PH_END;
			end
			dtfp_pkg::PH_FRAC: begin
				if (!is_digit) phase_d = dtfp_pkg::PH_END;
			end
			dtfp_pkg::PH_END: phase_d = dtfp_pkg::PH_END;
			default:          phase_d = dtfp_pkg::PH_END;
		endcase
	end

	always_comb begin
		int_en  = 1'b0;
		frac_en = 1'b0;
		neg_set = 1'b0;
		unique case (phase_q)
			dtfp_pkg::PH_WS: begin
				int_en  = is_digit;
				neg_set = (ch == dtfp_pkg::CH_MINUS);
			end
			dtfp_pkg::PH_INT:  int_en  = is_digit;
			dtfp_pkg::PH_FRAC: frac_en = is_digit && (cnt_q < CNT_W'(MAX_FRAC_DIGITS));
			default: begin
			end
		endcase
	end

	assign rec_push = take && is_nul;
	assign rec_neg  = neg_q;
	assign rec_int  = int_q;
	assign rec_ovf  = ovf_q;
	assign rec_frac = frac_q;
	assign rec_cnt  = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dtfp_pkg::PH_WS;
			neg_q   <= 1'b0;
			int_q   <= '0;
			ovf_q   <= 1'b0;
			frac_q  <= '0;
			cnt_q   <= '0;
		end else if (take) begin
			if (is_nul) begin
				// string done: start over for the next one
				phase_q <= dtfp_pkg::PH_WS;
				neg_q   <= 1'b0;
				int_q   <= '0;
				ovf_q   <= 1'b0;
				frac_q  <= '0;
				cnt_q   <= '0;
			end else begin
				phase_q <= phase_d;
				if (neg_set) neg_q <= 1'b1;
				if (int_en && !ovf_q) begin
					if (int_next[35:32] != 4'd0) begin
						ovf_q <= 1'b1;
						int_q <= '1;
					end else begin
						int_q <= int_next[31:0];
					end
				end
				if (frac_en) begin
					frac_q <= frac_next[FRAC_W-1:0];
					cnt_q  <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

endmodule

FILE: hw/rtl/dtfp_fifo.sv
// ----------------------------------------------------------------------------
// dtfp_fifo: two-entry queue of parsed number records
// Decouples the character parser from the scaling back end.
// ----------------------------------------------------------------------------
module dtfp_fifo #(
	parameter int W = 70
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         not_empty,
	output logic         is_full
);

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   cnt_q;

	assign rd_data   = mem_q[rd_ptr_q];
	assign not_empty = (cnt_q != 2'd0);
	assign is_full   = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) wr_ptr_q <= ~wr_ptr_q;
			if (rd_en) rd_ptr_q <= ~rd_ptr_q;
			unique case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/dtfp_back.sv
// ----------------------------------------------------------------------------
// dtfp_back: fraction scaling, saturation and result register
// Restoring division one quotient bit per cycle, then clamp and negate.
// ----------------------------------------------------------------------------
module dtfp_back #(
	parameter int FRAC_BITS = 24,
	parameter int FRAC_W    = 30,
	parameter int CNT_W     = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rec_valid,
	input  logic               rec_neg,
	input  logic [31:0]        rec_int,
	input  logic               rec_ovf,
	input  logic [FRAC_W-1:0]  rec_frac,
	input  logic [CNT_W-1:0]   rec_cnt,
	output logic               rec_pop,
	input  logic               pop,
	output logic               empty,
	output logic signed [31:0] value,
	output logic               saturated
);

	localparam int BW = $clog2(FRAC_BITS + 1);

	dtfp_pkg::back_state_t state_q, state_d;

	logic              neg_q, ovf_q;
	logic [31:0]       int_q;
	logic [FRAC_W-1:0] rem_q, den_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [BW-1:0]     bit_q;

	logic               out_valid_q, sat_q;
	logic signed [31:0] value_q;

	logic slot_free, step_en, fin_en;
	logic [63:0]     den_full;
	logic [FRAC_W:0] rem_sh;
	logic [FRAC_W:0] rem_sub;
	logic            rem_ge;
	logic [31:0] limit, int_lim, mag32, res32;
	logic [33:0] mag;
	logic        sat;

	assign slot_free = !out_valid_q || pop;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dtfp_pkg::BK_IDLE: if (rec_valid) state_d = dtfp_pkg::BK_DIV;
			dtfp_pkg::BK_DIV:  if (bit_q == BW'(1)) state_d = dtfp_pkg::BK_FIN;
			dtfp_pkg::BK_FIN:  if (slot_free) state_d = dtfp_pkg::BK_IDLE;
			default:           state_d = dtfp_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		rec_pop = 1'b0;
		step_en = 1'b0;
		fin_en  = 1'b0;
		unique case (state_q)
			dtfp_pkg::BK_IDLE: rec_pop = rec_valid;
			dtfp_pkg::BK_DIV:  step_en = 1'b1;
			dtfp_pkg::BK_FIN:  fin_en  = slot_free;
			default: begin
			end
		endcase
	end

	// divisor for the kept digit count
	assign den_full = dtfp_pkg::pow10(5'(rec_cnt));

	// one restoring step: remainder stays below the divisor
	assign rem_sh  = {rem_q, 1'b0};
	assign rem_ge  = (rem_sh >= {1'b0, den_q});
	assign rem_sub = rem_sh - {1'b0, den_q};

	// clamp and sign
	assign limit   = neg_q ? dtfp_pkg::LIMIT_NEG : dtfp_pkg::LIMIT_POS;
	assign int_lim = limit >> FRAC_BITS;
	assign mag     = 34'({32'd0, int_q} << FRAC_BITS) + 34'(quo_q);
	assign sat     = ovf_q || (int_q > int_lim) || (mag > {2'b00, limit});
	assign mag32   = sat ? limit : mag[31:0];
	assign res32   = neg_q ? (~mag32 + 32'd1) : mag32;

	always_ff @(posedge clk) begin
		if (rec_pop) begin
			neg_q <= rec_neg;
			ovf_q <= rec_ovf;
			int_q <= rec_int;
			rem_q <= rec_frac;
			den_q <= den_full[FRAC_W-1:0];
			quo_q <= '0;
		end else if (step_en) begin
			rem_q <= rem_ge ? rem_sub[FRAC_W-1:0] : rem_sh[FRAC_W-1:0];
			quo_q <= {quo_q[FRAC_BITS-2:0], rem_ge};
		end
		if (fin_en) begin
			value_q <= $signed(res32);
			sat_q   <= sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dtfp_pkg::BK_IDLE;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rec_pop)      bit_q <= BW'(FRAC_BITS);
			else if (step_en) bit_q <= bit_q - BW'(1);
			if (fin_en)                   out_valid_q <= 1'b1;
			else if (pop && out_valid_q)  out_valid_q <= 1'b0;
		end
	end

	assign empty     = !out_valid_q;
	assign value     = value_q;
	assign saturated = sat_q;

endmodule

FILE: hw/rtl/decimal_text_to_fixed_point.sv
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point: decimal string to signed fixed point
// Parses one character per beat and delivers one Q(31-FRAC_BITS).FRAC_BITS
// value per NUL-terminated string.
// ----------------------------------------------------------------------------
// Usage
//   Input queue: drive ch and raise push; a beat is taken on a clock edge
//   with push high and full low, one character per cycle while full is low.
//   full rises only while two parsed strings wait for the scaler, and then
//   holds off every character until the scaler takes one.
//   Output queue: while empty is low, value/saturated show the oldest result;
//   pop on a cycle with empty low takes it. One result per NUL character.
//   When the scaler is idle, a NUL beat writes its record to the queue; the
//   scaler then loads it, runs FRAC_BITS division steps and a clamp/sign step.
//   The bit-serial scaler takes the next string only once it is through with
//   the last; the parser runs at one character per cycle while full is low.
//   A stalled receiver holds its result; the scaler then waits with the next
//   finished value and the record queue fills, after which full holds off
//   the input.
//   Reset (arst_n low) empties both queues and returns the parser to the
//   leading-whitespace phase; no clearing pass is needed.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point #(
	parameter int MAX_FRAC_DIGITS = 9,
	parameter int FRAC_BITS       = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         ch,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] value,
	output logic               saturated
);

	// width of the kept fraction digits and of their count
	localparam logic [63:0] POW_MAX = dtfp_pkg::pow10(5'(MAX_FRAC_DIGITS));
	localparam int FRAC_W = $clog2(POW_MAX);
	localparam int CNT_W  = $clog2(MAX_FRAC_DIGITS + 1);
	localparam int REC_W  = 1 + 32 + 1 + FRAC_W + CNT_W;

	logic              take;
	logic              f_push, f_neg, f_ovf;
	logic [31:0]       f_int;
	logic [FRAC_W-1:0] f_frac;
	logic [CNT_W-1:0]  f_cnt;

	logic [REC_W-1:0]  q_wr, q_rd;
	logic              q_not_empty, q_full, q_pop;

	logic              b_neg, b_ovf;
	logic [31:0]       b_int;
	logic [FRAC_W-1:0] b_frac;
	logic [CNT_W-1:0]  b_cnt;

	// accept a character unless the record queue is out of room
	assign full = q_full;
	assign take = push && !q_full;

	dtfp_front #(
		.MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
		.FRAC_W          (FRAC_W),
		.CNT_W           (CNT_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.ch       (ch),
		.rec_push (f_push),
		.rec_neg  (f_neg),
		.rec_int  (f_int),
		.rec_ovf  (f_ovf),
		.rec_frac (f_frac),
		.rec_cnt  (f_cnt)
	);

	assign q_wr = {f_neg, f_int, f_ovf, f_frac, f_cnt};
	assign {b_neg, b_int, b_ovf, b_frac, b_cnt} = q_rd;

	dtfp_fifo #(
		.W (REC_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (f_push),
		.wr_data   (q_wr),
		.rd_en     (q_pop),
		.rd_data   (q_rd),
		.not_empty (q_not_empty),
		.is_full   (q_full)
	);

	dtfp_back #(
		.FRAC_BITS (FRAC_BITS),
		.FRAC_W    (FRAC_W),
		.CNT_W     (CNT_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (q_not_empty),
		.rec_neg   (b_neg),
		.rec_int   (b_int),
		.rec_ovf   (b_ovf),
		.rec_frac  (b_frac),
		.rec_cnt   (b_cnt),
		.rec_pop   (q_pop),
		.pop       (pop),
		.empty     (empty),
		.value     (value),
		.saturated (saturated)
	);

endmodule

FILE: hw/rtl/dtfp_checker.sv
// ----------------------------------------------------------------------------
// dtfp_port_checks: port-level checks for the decimal text parser
// Watches the two queue channels of the top level; bound in below.
// ----------------------------------------------------------------------------
module dtfp_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic [7:0]  ch,
	input logic        empty,
	input logic        pop,
	input logic [31:0] value,
	input logic        saturated
);

	// a clamped result is one of the two range ends
	a_sat_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && saturated) |->
			(value == dtfp_pkg::LIMIT_POS || value == dtfp_pkg::LIMIT_NEG))
		else $error("saturated result is not a range end");

	// the record queue only fills up on a NUL beat
	a_full_on_nul: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full && (ch == dtfp_pkg::CH_NUL)))
		else $error("full rose without a NUL beat");

	// reset empties both sides
	a_reset_clear: assert property (@(posedge clk)
		!arst_n |=> (empty && !full))
		else $error("queues not cleared in reset");

	// a waiting result holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(value) && $stable(saturated)))
		else $error("waiting result changed");

endmodule

bind decimal_text_to_fixed_point dtfp_port_checks u_dtfp_port_checks (.*);
